FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the token lexer
// Both macros sample on clk and stay quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge out of reset.
`define CTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after trig.
`define CTL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define CTL_ASSERT(lbl, prop, msg)
`define CTL_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

FILE: rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// Types, codes and character helpers for the C token lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int IDENT_CAPACITY_DEF = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] token_value;
    logic [3:0]  error_code;
    logic        last;
  } out_item_t;

  // token kinds
  localparam logic [2:0] TK_NAME_CHAR = 3'd0;
  localparam logic [2:0] TK_INT       = 3'd1;
  localparam logic [2:0] TK_CHAR      = 3'd2;
  localparam logic [2:0] TK_END       = 3'd3;
  localparam logic [2:0] TK_ERROR     = 3'd4;

  // error codes
  localparam logic [3:0] E_BAD_HEX     = 4'd0;
  localparam logic [3:0] E_IDENT_LONG  = 4'd1;
  localparam logic [3:0] E_EOF_IDENT   = 4'd2;
  localparam logic [3:0] E_EOF_ZERO    = 4'd3;
  localparam logic [3:0] E_EOF_HEX0    = 4'd4;
  localparam logic [3:0] E_EOF_HEXESC  = 4'd5;
  localparam logic [3:0] E_EOF_ESC     = 4'd6;
  localparam logic [3:0] E_EOF_CHAR    = 4'd7;
  localparam logic [3:0] E_NO_QUOTE    = 4'd8;
  localparam logic [3:0] E_UNKNOWN     = 4'd9;
  localparam logic [3:0] E_STRING      = 4'd10;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_IDENT = 4'd1,
    M_ZERO  = 4'd2,
    M_OCT   = 4'd3,
    M_DEC   = 4'd4,
    M_HEX0  = 4'd5,
    M_HEX   = 4'd6,
    M_CH0   = 4'd7,
    M_ESC   = 4'd8,
    M_XH1   = 4'd9,
    M_XH2   = 4'd10,
    M_CLOSE = 4'd11,
    M_HALT  = 4'd12
  } mode_t;

  // output sequencer
  typedef enum logic [2:0] {
    SQ_IN   = 3'd0,
    SQ_FRD  = 3'd1,
    SQ_FOUT = 3'd2,
    SQ_RA   = 3'd3,
    SQ_RB   = 3'd4
  } seq_t;

  // character codes
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_A_LC   = 8'h61;
  localparam logic [7:0] CH_B_LC   = 8'h62;
  localparam logic [7:0] CH_F_LC   = 8'h66;
  localparam logic [7:0] CH_N_LC   = 8'h6E;
  localparam logic [7:0] CH_R_LC   = 8'h72;
  localparam logic [7:0] CH_T_LC   = 8'h74;
  localparam logic [7:0] CH_V_LC   = 8'h76;
  localparam logic [7:0] CH_X_LC   = 8'h78;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    return c & ~CASE_BIT;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_NL, CH_CR, CH_TAB, CH_SPACE};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c inside {[CH_0:CH_7]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (upper_of(c) inside {[CH_UA:CH_UF]});
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return (upper_of(c) inside {[CH_UA:CH_UZ]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_ident_body(input logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_digit(c)) begin
      t = c - CH_0;
    end else begin
      t = upper_of(c) - CH_UA + HEX_LETTER_BASE;
    end
    return t[3:0];
  endfunction

  function automatic logic [7:0] esc_val(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_A_LC: v = 8'd7;
      CH_B_LC: v = 8'd8;
      CH_T_LC: v = 8'd9;
      CH_N_LC: v = 8'd10;
      CH_V_LC: v = 8'd11;
      CH_F_LC: v = 8'd12;
      CH_R_LC: v = 8'd13;
      CH_0:    v = 8'd0;
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic out_item_t err_res(input logic [3:0] code);
    out_item_t r;
    r.token_kind  = TK_ERROR;
    r.token_value = '0;
    r.error_code  = code;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic out_item_t tok_res(input logic [2:0] kind, input logic [31:0] value);
    out_item_t r;
    r.token_kind  = kind;
    r.token_value = value;
    r.error_code  = '0;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/c_token_lexer.sv
// ----------------------------------------------------------------------------
// c_token_lexer: streaming C tokenizer, one source byte per transfer
// Each identifier char of a flush is read from the identifier buffer memory
// and then sent; input is held off until every result of an item is out.
// Synchronous active-low reset returns the scanner to idle; the identifier
// buffer is not cleared, it is always written before it is read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c_token_lexer
  import ctl_pkg::*;
#(
  parameter int IDENT_CAPACITY = IDENT_CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int LW = $clog2(IDENT_CAPACITY);

  // scanner state
  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]  lit_r, lit_nxt;

  // identifier buffer memory
  logic [7:0]    ident_mem [IDENT_CAPACITY];
  logic [7:0]    rd_data_r;
  logic          mem_re;
  logic          mem_we;
  logic [LW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // sequencer and pending results
  seq_t          seq_r, seq_nxt;
  out_item_t     ra_r, rb_r;
  logic          ra_v_r, rb_v_r;
  logic [LW-1:0] fl_len_r, fl_idx_r;
  logic          wr_pend_r;
  logic [7:0]    wr_pend_data_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_nxt;
  logic      load_out;
  logic      out_free;

  // decode of the accepted item
  logic          in_acc;
  logic          dec_flush;
  logic          ra_v, rb_v;
  out_item_t     ra, rb;
  logic          ts;
  logic          ts_wr;
  logic          wr_body;
  logic          wr_now;
  logic [LW-1:0] wr_addr;
  logic          tres_v;
  out_item_t     tres;
  logic [7:0]    c;
  logic          eoi;
  logic [7:0]    dig;
  logic          fl_final;
  logic          flush_end;

  assign c        = in_data.ch;
  assign eoi      = in_data.end_of_input;
  assign dig      = c - CH_0;
  assign in_ready = (seq_r == SQ_IN);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign fl_final = (fl_idx_r == fl_len_r - LW'(1));
  assign flush_end = (seq_r == SQ_FOUT) && out_free && fl_final;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Scanner decode: next mode, accumulators and up to two non-identifier
  // results. An identifier flush, if any, goes out before those results.
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    lit_nxt   = lit_r;
    dec_flush = 1'b0;
    ra_v      = 1'b0;
    rb_v      = 1'b0;
    ra        = '0;
    rb        = '0;
    ts        = 1'b0;
    ts_wr     = 1'b0;
    wr_body   = 1'b0;
    tres_v    = 1'b0;
    tres      = '0;

    case (mode_r)
      M_IDLE: begin
        ts = 1'b1;
      end
      M_IDENT: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_IDENT); mode_nxt = M_HALT;
        end else if (is_ident_body(c)) begin
          if (len_r >= LW'(IDENT_CAPACITY - 1)) begin
            ra_v = 1'b1; ra = err_res(E_IDENT_LONG); mode_nxt = M_HALT;
          end else begin
            wr_body = 1'b1;
            len_nxt = len_r + LW'(1);
          end
        end else begin
          // the identifier ends here: flush it, then restart on this byte
          dec_flush = 1'b1;
          ts        = 1'b1;
        end
      end
      M_ZERO: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_ZERO); mode_nxt = M_HALT;
        end else if (upper_of(c) == CH_UX) begin
          mode_nxt = M_HEX0;
        end else if (is_oct(c)) begin
          acc_nxt  = 32'(dig);
          mode_nxt = M_OCT;
        end else begin
          ra_v = 1'b1; ra = tok_res(TK_INT, acc_r); ts = 1'b1;
        end
      end
      M_OCT: begin
        if (!eoi && is_oct(c)) begin
          acc_nxt = {acc_r[28:0], 3'b000} + 32'(dig);
        end else begin
          ra_v = 1'b1; ra = tok_res(TK_INT, acc_r); ts = 1'b1;
        end
      end
      M_DEC: begin
        if (!eoi && is_digit(c)) begin
          acc_nxt = 32'(acc_r * 32'd10) + 32'(dig);
        end else begin
          ra_v = 1'b1; ra = tok_res(TK_INT, acc_r); ts = 1'b1;
        end
      end
      M_HEX0, M_HEX: begin
        if (eoi && (mode_r == M_HEX0)) begin
          ra_v = 1'b1; ra = err_res(E_EOF_HEX0); mode_nxt = M_HALT;
        end else if (!eoi && is_hex(c)) begin
          acc_nxt  = {acc_r[27:0], hex_val(c)};
          mode_nxt = M_HEX;
        end else begin
          ra_v = 1'b1; ra = tok_res(TK_INT, acc_r); ts = 1'b1;
        end
      end
      M_CH0: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_CHAR); mode_nxt = M_HALT;
        end else if (c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          lit_nxt  = c;
          mode_nxt = M_CLOSE;
        end
      end
      M_ESC: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_ESC); mode_nxt = M_HALT;
        end else if (c == CH_X_LC) begin
          mode_nxt = M_XH1;
        end else begin
          lit_nxt  = esc_val(c);
          mode_nxt = M_CLOSE;
        end
      end
      M_XH1: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_HEXESC); mode_nxt = M_HALT;
        end else begin
          lit_nxt  = c;
          mode_nxt = M_XH2;
        end
      end
      M_XH2: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_HEXESC); mode_nxt = M_HALT;
        end else if (!is_hex(lit_r) || !is_hex(c)) begin
          ra_v = 1'b1; ra = err_res(E_BAD_HEX); mode_nxt = M_HALT;
        end else begin
          lit_nxt  = {hex_val(lit_r), hex_val(c)};
          mode_nxt = M_CLOSE;
        end
      end
      M_CLOSE: begin
        if (eoi) begin
          ra_v = 1'b1; ra = err_res(E_EOF_CHAR); mode_nxt = M_HALT;
        end else if (c != CH_SQUOTE) begin
          ra_v = 1'b1; ra = err_res(E_NO_QUOTE); mode_nxt = M_HALT;
        end else begin
          ra_v = 1'b1; ra = tok_res(TK_CHAR, 32'(lit_r)); mode_nxt = M_IDLE;
        end
      end
      default: begin
        // halted: swallow every item until reset
      end
    endcase

    // start of a new token on the current byte
    if (ts) begin
      mode_nxt = M_IDLE;
      if (eoi) begin
        tres_v = 1'b1; tres = tok_res(TK_END, '0);
      end else if (is_space(c)) begin
        tres_v = 1'b0;
      end else if (is_ident_start(c)) begin
        ts_wr    = 1'b1;
        len_nxt  = LW'(1);
        mode_nxt = M_IDENT;
      end else if (is_digit(c)) begin
        acc_nxt  = 32'(dig);
        mode_nxt = (c == CH_0) ? M_ZERO : M_DEC;
      end else if (c == CH_DQUOTE) begin
        tres_v = 1'b1; tres = err_res(E_STRING); mode_nxt = M_HALT;
      end else if (c == CH_SQUOTE) begin
        mode_nxt = M_CH0;
      end else begin
        tres_v = 1'b1; tres = err_res(E_UNKNOWN); mode_nxt = M_HALT;
      end
      if (tres_v) begin
        if (ra_v) begin
          rb_v = 1'b1; rb = tres;
        end else begin
          ra_v = 1'b1; ra = tres;
        end
      end
    end

    // a new identifier's first byte waits until the old one is flushed
    wr_now  = wr_body || (ts_wr && !dec_flush);
    wr_addr = ts_wr ? '0 : len_r;
  end

  // --------------------------------------------------------------------------
  // Output sequencer: flush identifier chars (read, then send), then the
  // first and second pending results. Input is held off until all are out.
  // --------------------------------------------------------------------------
  always_comb begin
    seq_nxt  = seq_r;
    mem_re   = 1'b0;
    load_out = 1'b0;
    out_nxt  = ra_r;
    case (seq_r)
      SQ_IN: begin
        if (in_acc) begin
          if (dec_flush) begin
            seq_nxt = SQ_FRD;
          end else if (ra_v) begin
            seq_nxt = SQ_RA;
          end
        end
      end
      SQ_FRD: begin
        mem_re  = 1'b1;
        seq_nxt = SQ_FOUT;
      end
      SQ_FOUT: begin
        out_nxt      = tok_res(TK_NAME_CHAR, 32'(rd_data_r));
        out_nxt.last = fl_final && !ra_v_r;
        if (out_free) begin
          load_out = 1'b1;
          if (fl_final) begin
            seq_nxt = ra_v_r ? SQ_RA : SQ_IN;
          end else begin
            seq_nxt = SQ_FRD;
          end
        end
      end
      SQ_RA: begin
        out_nxt      = ra_r;
        out_nxt.last = !rb_v_r;
        if (out_free) begin
          load_out = 1'b1;
          seq_nxt  = rb_v_r ? SQ_RB : SQ_IN;
        end
      end
      SQ_RB: begin
        out_nxt      = rb_r;
        out_nxt.last = 1'b1;
        if (out_free) begin
          load_out = 1'b1;
          seq_nxt  = SQ_IN;
        end
      end
      default: begin
        seq_nxt = SQ_IN;
      end
    endcase
  end

  // Write either the byte just accepted or the held first byte of the next
  // identifier; the two never fall in the same cycle.
  assign mem_we = (in_acc && wr_now) || (flush_end && wr_pend_r);
  assign mem_wa = in_acc ? wr_addr : '0;
  assign mem_wd = in_acc ? c : wr_pend_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ident_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= ident_mem[fl_idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_IN;
      mode_r      <= M_IDLE;
      acc_r       <= '0;
      len_r       <= '0;
      lit_r       <= '0;
      ra_v_r      <= 1'b0;
      rb_v_r      <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (in_acc) begin
        mode_r    <= mode_nxt;
        acc_r     <= acc_nxt;
        len_r     <= len_nxt;
        lit_r     <= lit_nxt;
        ra_v_r    <= ra_v;
        rb_v_r    <= rb_v;
        wr_pend_r <= ts_wr && dec_flush;
      end else if (flush_end) begin
        wr_pend_r <= 1'b0;
      end
      // hold the result until the far side takes it
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ra_r           <= ra;
      rb_r           <= rb;
      fl_len_r       <= len_r;
      fl_idx_r       <= '0;
      wr_pend_data_r <= c;
    end else if ((seq_r == SQ_FOUT) && out_free && !fl_final) begin
      fl_idx_r <= fl_idx_r + LW'(1);
    end
    if (load_out) begin
      out_data_r <= out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CTL_ASSERT(a_flush_in_range, (seq_r == SQ_FOUT) |-> (fl_idx_r < fl_len_r), "flush index out of range")
  `CTL_ASSERT(a_err_halts, (out_valid_r && (out_data_r.token_kind == TK_ERROR)) |-> (mode_r == M_HALT), "error sent but scanner not halted")
  `CTL_ASSERT(a_pend_in_flush, wr_pend_r |-> ((seq_r == SQ_FRD) || (seq_r == SQ_FOUT)), "held write outside flush")
  `CTL_ASSERT_NEXT(a_halt_silent, in_acc && (mode_r == M_HALT), (seq_r == SQ_IN) && (mode_r == M_HALT), "halted scanner produced work")

endmodule
